[design/wpsu_pkg.sv]
// Shared types and constants for the WAV PCM stream unpacker.
`default_nettype none

package wpsu_pkg;

	// Parse phase, one-hot
	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_DATA   = 3'b010,
		PH_REJECT = 3'b100
	} phase_t;

	// Kind of result item
	typedef enum logic [1:0] {
		KIND_ACCEPT = 2'd0,
		KIND_REJECT = 2'd1,
		KIND_FRAME  = 2'd2
	} kind_t;

	// Position of the last header byte
	localparam logic [5:0] HEADER_LAST = 6'd43;

	// Header values captured from the format and data chunks
	typedef struct packed {
		logic [15:0] format_tag;
		logic [15:0] channel_total;
		logic [15:0] bits_per_sample;
		logic [31:0] sample_rate;
		logic [31:0] data_length;
	} hdr_info_t;

	// Control from the header parser to the frame path and result mux
	typedef struct packed {
		logic done;
		logic ok;
		logic frame_take;
		logic frame_clear;
	} hdr_ctl_t;

	// One result item
	typedef struct packed {
		kind_t            kind;
		logic signed [31:0] left;
		logic signed [31:0] right;
		hdr_info_t        info;
	} result_t;

endpackage

`default_nettype wire

[design/wpsu_hdr.sv]
// Header parser: phase, byte position, tag check and field capture.
`default_nettype none

module wpsu_hdr (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire logic [7:0]          data_byte,
	input  wire logic                start_of_file,
	output wpsu_pkg::hdr_info_t      info,
	output wpsu_pkg::hdr_ctl_t       ctl
);

	localparam logic [7:0] TagText [16] = '{
		8'h52, 8'h49, 8'h46, 8'h46,   // RIFF
		8'h57, 8'h41, 8'h56, 8'h45,   // WAVE
		8'h66, 8'h6d, 8'h74, 8'h20,   // fmt
		8'h64, 8'h61, 8'h74, 8'h61    // data
	};

	wpsu_pkg::phase_t    phase_q, phase_eff, phase_nxt;
	logic [5:0]          count_q, pos;
	logic                mismatch_q, mismatch_nxt;
	wpsu_pkg::hdr_info_t info_q, info_nxt;
	logic                tag_hit;
	logic [3:0]          tag_idx;
	logic                in_header, done, ok;

	// A start mark restarts the parse at byte zero
	assign phase_eff = start_of_file ? wpsu_pkg::PH_HEADER : phase_q;
	assign pos       = start_of_file ? 6'd0 : count_q;
	assign in_header = (phase_eff == wpsu_pkg::PH_HEADER);

	// Locate the expected tag byte for this position
	always_comb begin
		tag_hit = 1'b1;
		tag_idx = 4'd0;
		if (pos < 6'd4) begin
			tag_idx = {2'b00, pos[1:0]};
		end else if (pos >= 6'd8 && pos < 6'd12) begin
			tag_idx = {2'b01, pos[1:0]};
		end else if (pos >= 6'd12 && pos < 6'd16) begin
			tag_idx = {2'b10, pos[1:0]};
		end else if (pos >= 6'd36 && pos < 6'd40) begin
			tag_idx = {2'b11, pos[1:0]};
		end else begin
			tag_hit = 1'b0;
		end
	end

	// Capture little-endian fields, clearing them on byte zero
	always_comb begin
		info_nxt     = (pos == 6'd0) ? '0 : info_q;
		mismatch_nxt = (pos == 6'd0) ? 1'b0 : mismatch_q;
		if (tag_hit && data_byte != TagText[tag_idx]) begin
			mismatch_nxt = 1'b1;
		end
		if (pos >= 6'd20 && pos < 6'd22) begin
			info_nxt.format_tag[{pos[0], 3'b000} +: 8] = data_byte;
		end else if (pos >= 6'd22 && pos < 6'd24) begin
			info_nxt.channel_total[{pos[0], 3'b000} +: 8] = data_byte;
		end else if (pos >= 6'd24 && pos < 6'd28) begin
			info_nxt.sample_rate[{pos[1:0], 3'b000} +: 8] = data_byte;
		end else if (pos >= 6'd34 && pos < 6'd36) begin
			info_nxt.bits_per_sample[{pos[0], 3'b000} +: 8] = data_byte;
		end else if (pos >= 6'd40 && pos < 6'd44) begin
			info_nxt.data_length[{pos[1:0], 3'b000} +: 8] = data_byte;
		end
	end

	// Judge the header on its last byte
	assign done = accept && in_header && (pos >= wpsu_pkg::HEADER_LAST);
	assign ok   = !mismatch_nxt &&
		(info_nxt.channel_total == 16'd1 || info_nxt.channel_total == 16'd2) &&
		(info_nxt.bits_per_sample == 16'd8 || info_nxt.bits_per_sample == 16'd16 ||
		 info_nxt.bits_per_sample == 16'd24 || info_nxt.bits_per_sample == 16'd32);

	// Pick the next phase
	always_comb begin
		phase_nxt = phase_q;
		case (phase_eff)
			wpsu_pkg::PH_HEADER: begin
				if (done) begin
					phase_nxt = ok ? wpsu_pkg::PH_DATA : wpsu_pkg::PH_REJECT;
				end else begin
					phase_nxt = wpsu_pkg::PH_HEADER;
				end
			end
			default: begin
				phase_nxt = phase_q;
			end
		endcase
	end

	// Advance phase, position and captured fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= wpsu_pkg::PH_HEADER;
			count_q    <= '0;
			mismatch_q <= 1'b0;
			info_q     <= '0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			if (in_header) begin
				count_q    <= done ? 6'd0 : pos + 6'd1;
				mismatch_q <= mismatch_nxt;
				info_q     <= info_nxt;
			end
		end
	end

	assign info            = in_header ? info_nxt : info_q;
	assign ctl.done        = done;
	assign ctl.ok          = ok;
	assign ctl.frame_take  = accept && (phase_eff == wpsu_pkg::PH_DATA);
	assign ctl.frame_clear = accept && (start_of_file || done);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= wpsu_pkg::HEADER_LAST)
		else $error("header position past last header byte");

	a_done_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (count_q == 6'd0 && phase_q != wpsu_pkg::PH_HEADER))
		else $error("header end did not leave the header phase");

endmodule

`default_nettype wire

[design/wpsu_frame.sv]
// Frame path: byte buffer, frame byte count and Q1.31 conversion.
`default_nettype none

module wpsu_frame (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [7:0]          data_byte,
	input  wire wpsu_pkg::hdr_info_t info,
	input  wire wpsu_pkg::hdr_ctl_t  ctl,
	output logic                     frame_done,
	output logic signed [31:0]       left,
	output logic signed [31:0]       right
);

	logic [7:0] fbuf_q [8];
	logic [7:0] fb [8];
	logic [2:0] count_q;
	logic [2:0] bps;
	logic [3:0] fbytes;
	logic       last, stereo;

	function automatic logic [31:0] to_q31(input logic [2:0] nbytes,
		input logic [7:0] b0, input logic [7:0] b1,
		input logic [7:0] b2, input logic [7:0] b3);
		logic [31:0] v;
		case (nbytes)
			3'd1:    v = {b0 ^ 8'h80, 24'd0};
			3'd2:    v = {b1, b0, 16'd0};
			3'd3:    v = {b2, b1, b0, 8'd0};
			default: v = {b3, b2, b1, b0};
		endcase
		return v;
	endfunction

	// Bytes per sample and per frame
	assign bps    = info.bits_per_sample[5:3];
	assign stereo = (info.channel_total == 16'd2);
	assign fbytes = stereo ? {bps, 1'b0} : {1'b0, bps};
	assign last   = (({1'b0, count_q} + 4'd1) == fbytes);

	// Overlay the current byte on the buffer
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			fb[i] = (count_q == 3'(i)) ? data_byte : fbuf_q[i];
		end
	end

	assign frame_done = ctl.frame_take && last;
	assign left  = to_q31(bps, fb[0], fb[1], fb[2], fb[3]);
	assign right = stereo ? to_q31(bps, fb[bps], fb[3'(bps + 3'd1)],
		fb[3'(bps + 3'd2)], fb[3'(bps + 3'd3)]) : left;

	// Advance the frame byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.frame_clear) begin
			count_q <= '0;
		end else if (ctl.frame_take) begin
			count_q <= last ? 3'd0 : count_q + 3'd1;
		end
	end

	// Store the byte in its frame slot
	always_ff @(posedge clk) begin
		if (ctl.frame_take) begin
			fbuf_q[count_q] <= data_byte;
		end
	end

	a_count_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.frame_take |-> ({1'b0, count_q} < fbytes))
		else $error("frame byte count past frame size");

endmodule

`default_nettype wire

[design/wpsu_out_buf.sv]
// Two-entry result queue: output register plus skid register.
`default_nettype none

module wpsu_out_buf (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire wpsu_pkg::result_t  push_item,
	output logic                    full,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output wpsu_pkg::result_t       out_item
);

	logic              head_valid_q, skid_valid_q;
	wpsu_pkg::result_t head_q, skid_q;
	logic              head_free;

	assign head_free = !head_valid_q || !out_stall;

	// Control: move skid to head, or park a new item in the skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (head_free) begin
			head_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (head_free) begin
			head_q <= skid_valid_q ? skid_q : push_item;
		end else if (push) begin
			skid_q <= push_item;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = head_valid_q;
	assign out_item  = head_q;

	a_skid_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> head_valid_q)
		else $error("skid holds an item while head is empty");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && skid_valid_q))
		else $error("item pushed into a full queue");

endmodule

`default_nettype wire

[design/wav_pcm_stream_unpacker.sv]
// Top level of the WAV PCM stream unpacker.
// Takes one WAV byte per cycle while in_stall is low and registers each result
// into the output queue on the byte that completes it: the header verdict on byte
// 44 and a left/right Q1.31 frame on the last byte of each frame. A two-entry
// result queue keeps bytes flowing while a result waits, and the input stalls
// only while two results are held, the second parked behind a stalled output.
`default_nettype none

module wav_pcm_stream_unpacker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [7:0]   data_byte,
	input  wire logic         start_of_file,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [1:0]        result_kind,
	output logic signed [31:0] left_sample,
	output logic signed [31:0] right_sample,
	output logic [31:0]       sample_rate,
	output logic [15:0]       channel_total,
	output logic [15:0]       bits_per_sample,
	output logic [15:0]       format_tag,
	output logic [31:0]       data_length
);

	logic                accept, frame_done, push;
	logic signed [31:0]  frame_left, frame_right;
	wpsu_pkg::hdr_info_t info;
	wpsu_pkg::hdr_ctl_t  ctl;
	wpsu_pkg::result_t   res, out_item;

	assign accept = in_valid && !in_stall;

	wpsu_hdr u_hdr (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (data_byte),
		.start_of_file (start_of_file),
		.info          (info),
		.ctl           (ctl)
	);

	wpsu_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_byte  (data_byte),
		.info       (info),
		.ctl        (ctl),
		.frame_done (frame_done),
		.left       (frame_left),
		.right      (frame_right)
	);

	// Build the result item
	always_comb begin
		res.info = info;
		if (ctl.done) begin
			res.kind  = ctl.ok ? wpsu_pkg::KIND_ACCEPT : wpsu_pkg::KIND_REJECT;
			res.left  = '0;
			res.right = '0;
		end else begin
			res.kind  = wpsu_pkg::KIND_FRAME;
			res.left  = frame_left;
			res.right = frame_right;
		end
	end

	assign push = ctl.done || frame_done;

	wpsu_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (res),
		.full      (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	assign result_kind     = out_item.kind;
	assign left_sample     = out_item.left;
	assign right_sample    = out_item.right;
	assign sample_rate     = out_item.info.sample_rate;
	assign channel_total   = out_item.info.channel_total;
	assign bits_per_sample = out_item.info.bits_per_sample;
	assign format_tag      = out_item.info.format_tag;
	assign data_length     = out_item.info.data_length;

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.done && frame_done))
		else $error("header verdict and frame on the same item");

	a_push_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> accept)
		else $error("result produced without an accepted item");

endmodule

`default_nettype wire
